// ----- hw/rtl/arss_pkg.sv -----
// Shared types and constants for the auction record segment statistics block.
`timescale 1ns / 1ps

package arss_pkg;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 216;
    localparam int M_TUSER_W = 3;

    localparam logic [15:0] DAY_MINUTES  = 16'(24 * 60);
    localparam logic [15:0] NOON_MINUTES = 16'(12 * 60);
    localparam logic [7:0]  SECS_PER_MIN = 8'(60);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_TIME   = 2'd1,
        ERR_PRICE  = 2'd2,
        ERR_FAILED = 2'd3
    } err_code_t;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_BUY  = 2'b01;
    localparam logic [1:0] DIR_SELL = 2'b11;

    // Classified record handed from the front end to the statistics engine.
    typedef struct packed {
        err_code_t   error_code;
        logic        opening;
        logic [16:0] day_second;
        logic [31:0] unmatched_magnitude;
        logic [1:0]  direction;
        logic [30:0] price_magnitude;
        logic [31:0] matched_volume;
        logic        last;
    } item_t;

    typedef struct packed {
        err_code_t   error_code;
        logic        opening_segment;
        logic [16:0] day_second;
        logic [31:0] unmatched_magnitude;
        logic [1:0]  direction;
        logic [15:0] seg_records;
        logic [30:0] lo_price_bits;
        logic [30:0] hi_price_bits;
        logic [31:0] peak_unmatched;
        logic [16:0] peak_unmatched_time;
        logic [15:0] direction_flips;
        logic [15:0] volume_regressions;
    } result_t;

endpackage

// ----- hw/rtl/auction_record_segment_stats_core.sv -----
// Top level of the auction record segment statistics block.
`timescale 1ns / 1ps
//
// One decoded auction record enters per transfer on the s_ channel (s_tlast marks
// the last record of a series) and exactly one result leaves per record on the
// m_ channel, in order. m_tuser carries the error code and the opening-segment
// flag; m_tdata carries the derived time, unmatched magnitude and direction and
// the updated statistics of the record's segment.
// A record is written into the queue on its input transfer; when the statistics
// engine pops it, it updates the segment registers and loads the output register
// with the result. One record is taken every cycle while the queue is not full.
// A four-entry queue sits between front end and engine. While the receiver holds
// m_tready low the output register keeps its result and the queue fills; s_tready
// falls only once the queue is full, and rises again as results drain.
// Reset clears the failure flag, both segments' statistics and the queue, and no
// result is pending after it. After a record marked last in series, all
// statistics and the failure flag return to their reset values.
// COUNT_WIDTH sets the saturation width of the point, flip and regression
// counters; results carry their low 16 bits.

module auction_record_segment_stats_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: minute[15:0], second_of_minute[23:16], price_bits[55:24],
    //          matched_volume[87:56], unmatched_signed[119:88]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [arss_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: day_second[16:0], unmatched_magnitude[48:17], direction[50:49],
    //          seg_records[66:51], lo_price_bits[97:67], hi_price_bits[128:98],
    //          peak_unmatched[160:129], peak_unmatched_time[177:161],
    //          direction_flips[193:178], volume_regressions[209:194], zero[215:210]
    output logic [arss_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: error_code[1:0], opening_segment[2]
    output logic [arss_pkg::M_TUSER_W-1:0] m_tuser
);

    logic              queue_full;
    logic              push;
    arss_pkg::item_t   push_item;
    logic              pop;
    logic              head_valid;
    arss_pkg::item_t   head_item;
    arss_pkg::result_t res;

    arss_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    arss_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    arss_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tuser = {res.opening_segment, res.error_code};
    assign m_tdata = {6'd0,
                      res.volume_regressions,
                      res.direction_flips,
                      res.peak_unmatched_time,
                      res.peak_unmatched,
                      res.hi_price_bits,
                      res.lo_price_bits,
                      res.seg_records,
                      res.direction,
                      res.unmatched_magnitude,
                      res.day_second};

endmodule

// ----- hw/rtl/arss_front.sv -----
// Front end: checks time and price, derives the record's fields, tracks series failure.
`timescale 1ns / 1ps

module arss_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [arss_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           queue_full,
    output logic                           push,
    output arss_pkg::item_t                push_item
);

    logic        series_failed_reg;
    logic        series_failed_next;
    logic [15:0] minute;
    logic [7:0]  second;
    logic [31:0] price;
    logic [31:0] matched;
    logic [31:0] unmatched;
    logic        time_bad;
    logic        price_bad;
    logic [16:0] minute_ext;
    arss_pkg::err_code_t err;

    assign minute    = s_tdata[15:0];
    assign second    = s_tdata[23:16];
    assign price     = s_tdata[55:24];
    assign matched   = s_tdata[87:56];
    assign unmatched = s_tdata[119:88];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    assign time_bad  = (minute >= arss_pkg::DAY_MINUTES) || (second >= arss_pkg::SECS_PER_MIN);
    // Minus zero passes; any other negative value or an all-ones exponent fails.
    assign price_bad = (price[30:23] == 8'hFF) || (price[31] && (price[30:0] != 31'd0));

    always_comb begin
        if (series_failed_reg) begin
            err = arss_pkg::ERR_FAILED;
        end else if (time_bad) begin
            err = arss_pkg::ERR_TIME;
        end else if (price_bad) begin
            err = arss_pkg::ERR_PRICE;
        end else begin
            err = arss_pkg::ERR_OK;
        end
    end

    // Only meaningful for a valid minute, which is below 2048.
    assign minute_ext = 17'(minute[10:0]);

    always_comb begin
        push_item.error_code          = err;
        push_item.opening             = (minute < arss_pkg::NOON_MINUTES);
        push_item.day_second          = (minute_ext << 6) - (minute_ext << 2)
                                        + 17'(second[5:0]);
        push_item.unmatched_magnitude = unmatched[31] ? (~unmatched + 32'd1) : unmatched;
        if (unmatched[31]) begin
            push_item.direction = arss_pkg::DIR_SELL;
        end else if (unmatched != 32'd0) begin
            push_item.direction = arss_pkg::DIR_BUY;
        end else begin
            push_item.direction = arss_pkg::DIR_NONE;
        end
        push_item.price_magnitude = price[30:0];
        push_item.matched_volume  = matched;
        push_item.last            = s_tlast;
    end

    always_comb begin
        series_failed_next = series_failed_reg;
        if (push) begin
            if (s_tlast) begin
                series_failed_next = 1'b0;
            end else if (err == arss_pkg::ERR_TIME || err == arss_pkg::ERR_PRICE) begin
                series_failed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            series_failed_reg <= 1'b0;
        end else begin
            series_failed_reg <= series_failed_next;
        end
    end

endmodule

// ----- hw/rtl/arss_queue.sv -----
// Short first-in first-out queue between the front end and the statistics engine.
`timescale 1ns / 1ps

module arss_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  arss_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output arss_pkg::item_t head_item
);

    arss_pkg::item_t               mem_reg [arss_pkg::QUEUE_DEPTH];
    logic [arss_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [arss_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [arss_pkg::QPTR_W:0]     count_reg;
    logic [arss_pkg::QPTR_W:0]     count_next;

    localparam logic [arss_pkg::QPTR_W:0] DEPTH_CNT = (arss_pkg::QPTR_W + 1)'(arss_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/arss_back.sv -----
// Statistics engine: updates the opening or closing segment and registers the result.
`timescale 1ns / 1ps

module arss_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  arss_pkg::item_t   head_item,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_ready,
    output arss_pkg::result_t res
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic                   seg_used_reg   [2];
    logic [COUNT_WIDTH-1:0] count_reg      [2];
    logic [30:0]            lo_price_reg   [2];
    logic [30:0]            hi_price_reg   [2];
    logic [31:0]            peak_reg       [2];
    logic [16:0]            peak_time_reg  [2];
    logic [31:0]            prev_matched_reg [2];
    logic [1:0]             prev_dir_reg   [2];
    logic [COUNT_WIDTH-1:0] flips_reg      [2];
    logic [COUNT_WIDTH-1:0] regress_reg    [2];

    logic                   out_valid_reg;
    arss_pkg::result_t      out_reg;
    arss_pkg::result_t      out_next;

    logic                   seg;
    logic                   has;
    logic                   item_ok;
    logic [30:0]            min_next;
    logic [30:0]            max_next;
    logic [31:0]            peak_next;
    logic [16:0]            peak_time_next;
    logic [1:0]             prev_dir_next;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] flips_next;
    logic [COUNT_WIDTH-1:0] regress_next;
    logic [31:0]            count_wide;
    logic [31:0]            flips_wide;
    logic [31:0]            regress_wide;

    assign pop       = head_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign seg     = !head_item.opening;
    assign has     = seg_used_reg[seg];
    assign item_ok = (head_item.error_code == arss_pkg::ERR_OK);

    always_comb begin
        if (!has) begin
            min_next       = head_item.price_magnitude;
            max_next       = head_item.price_magnitude;
            peak_next      = head_item.unmatched_magnitude;
            peak_time_next = head_item.day_second;
            regress_next   = regress_reg[seg];
        end else begin
            min_next = (head_item.price_magnitude < lo_price_reg[seg])
                       ? head_item.price_magnitude : lo_price_reg[seg];
            max_next = (head_item.price_magnitude > hi_price_reg[seg])
                       ? head_item.price_magnitude : hi_price_reg[seg];
            // A later equal peak keeps the time of the first one.
            if (head_item.unmatched_magnitude > peak_reg[seg]) begin
                peak_next      = head_item.unmatched_magnitude;
                peak_time_next = head_item.day_second;
            end else begin
                peak_next      = peak_reg[seg];
                peak_time_next = peak_time_reg[seg];
            end
            if (head_item.matched_volume < prev_matched_reg[seg]
                && regress_reg[seg] != CNT_MAX) begin
                regress_next = regress_reg[seg] + CNT_ONE;
            end else begin
                regress_next = regress_reg[seg];
            end
        end

        flips_next    = flips_reg[seg];
        prev_dir_next = prev_dir_reg[seg];
        if (head_item.direction != arss_pkg::DIR_NONE) begin
            if (prev_dir_reg[seg] != arss_pkg::DIR_NONE
                && prev_dir_reg[seg] != head_item.direction
                && flips_reg[seg] != CNT_MAX) begin
                flips_next = flips_reg[seg] + CNT_ONE;
            end
            prev_dir_next = head_item.direction;
        end

        count_next = (count_reg[seg] == CNT_MAX) ? count_reg[seg] : count_reg[seg] + CNT_ONE;
    end

    assign count_wide   = 32'(count_next);
    assign flips_wide   = 32'(flips_next);
    assign regress_wide = 32'(regress_next);

    always_comb begin
        out_next            = '0;
        out_next.error_code = head_item.error_code;
        if (item_ok) begin
            out_next.opening_segment     = head_item.opening;
            out_next.day_second          = head_item.day_second;
            out_next.unmatched_magnitude = head_item.unmatched_magnitude;
            out_next.direction           = head_item.direction;
            out_next.seg_records         = count_wide[15:0];
            out_next.lo_price_bits       = min_next;
            out_next.hi_price_bits       = max_next;
            out_next.peak_unmatched      = peak_next;
            out_next.peak_unmatched_time = peak_time_next;
            out_next.direction_flips     = flips_wide[15:0];
            out_next.volume_regressions  = regress_wide[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                seg_used_reg[i]     <= 1'b0;
                count_reg[i]        <= '0;
                lo_price_reg[i]     <= '0;
                hi_price_reg[i]     <= '0;
                peak_reg[i]         <= '0;
                peak_time_reg[i]    <= '0;
                prev_matched_reg[i] <= '0;
                prev_dir_reg[i]     <= arss_pkg::DIR_NONE;
                flips_reg[i]        <= '0;
                regress_reg[i]      <= '0;
            end
        end else begin
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
            // The end of a series wipes both segments, after its own result is formed.
            if (pop && head_item.last) begin
                for (int i = 0; i < 2; i++) begin
                    seg_used_reg[i]     <= 1'b0;
                    count_reg[i]        <= '0;
                    lo_price_reg[i]     <= '0;
                    hi_price_reg[i]     <= '0;
                    peak_reg[i]         <= '0;
                    peak_time_reg[i]    <= '0;
                    prev_matched_reg[i] <= '0;
                    prev_dir_reg[i]     <= arss_pkg::DIR_NONE;
                    flips_reg[i]        <= '0;
                    regress_reg[i]      <= '0;
                end
            end else if (pop && item_ok) begin
                seg_used_reg[seg]     <= 1'b1;
                count_reg[seg]        <= count_next;
                lo_price_reg[seg]     <= min_next;
                hi_price_reg[seg]     <= max_next;
                peak_reg[seg]         <= peak_next;
                peak_time_reg[seg]    <= peak_time_next;
                prev_matched_reg[seg] <= head_item.matched_volume;
                prev_dir_reg[seg]     <= prev_dir_next;
                flips_reg[seg]        <= flips_next;
                regress_reg[seg]      <= regress_next;
            end
        end
    end

endmodule

// ----- hw/rtl/arss_checker.sv -----
// Port-level checker for the auction record segment statistics block, with its bind.
`timescale 1ns / 1ps

module arss_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [arss_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [arss_pkg::M_TUSER_W-1:0] m_tuser
);

    // A stalled result holds still.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result is pending right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An error result carries nothing but its code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != 2'd0 |-> m_tdata == '0 && !m_tuser[2])
        else $error("error result carries data");

    // The segment flag agrees with the reported time of day.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == 2'd0 |-> m_tuser[2] == (m_tdata[16:0] < 17'd43200))
        else $error("segment flag disagrees with time");

    // Segment minimum never exceeds the maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == 2'd0 |-> m_tdata[97:67] <= m_tdata[128:98])
        else $error("segment minimum above maximum");

endmodule

bind auction_record_segment_stats_core arss_checker u_arss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
